### rtl/rlma_pkg.sv
`timescale 1ns / 1ps
// Shared widths and constants of the range low-pass and moving-average filter.
// No dependencies; used by the top level and its checker.
package rlma_pkg;

  localparam int WINDOW_LEN_DEF = 8;
  localparam int COUNTER_W      = 32;
  localparam int RAW_W          = 16;
  localparam int FRAC_W         = 8;
  localparam int DATA_W         = RAW_W + FRAC_W;
  localparam int GAIN_W         = 17;
  localparam int GAIN_FRAC_W    = 16;
  localparam int PROD_W         = GAIN_W + DATA_W;
  localparam int IN_DATA_W      = 48;
  localparam int OUT_DATA_W     = 48;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd16384;
  localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
  localparam logic [DATA_W-1:0] DATA_MAX   = 24'hFFFF00;

endpackage

### rtl/range_lowpass_moving_average.sv
`timescale 1ns / 1ps
// Range low-pass and moving-average filter: one-bit-per-cycle mean divider,
// window history in a synchronous memory. Depends on rlma_pkg.
// A new sample passes the decide, check, multiply, apply, write, divide and finish
// states; a repeated or zero counter or a sample without sample_ok skips from check
// to divide and repeats the held outputs. One item is in work at a time; the serial
// divider sets the rate. The input is ready again in the same cycle as the result
// turns valid; a stalled result holds the next one back.
// Reset clears all filter state and loads the default gain; the history memory
// is not cleared, since a read entry is only used once the window is full.
module range_lowpass_moving_average
  import rlma_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // sample_counter [31:0], raw_distance [47:32]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // sample_ok [0]
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // smoothed_distance [23:0], window_mean [47:24]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [GAIN_W-1:0]     cfg_data_i
);

  localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int TOT_W   = DATA_W + CNT_W;
  localparam int ITER_W  = $clog2(TOT_W + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECIDE, ST_CHECK, ST_MUL, ST_APPLY, ST_WRITE, ST_DIV, ST_FINISH
  } state_e;

  state_e                  state_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [COUNTER_W-1:0]    cnt_q, prev_q;
  logic                    ok_q;
  logic [RAW_W-1:0]        raw_q;
  logic [DATA_W-1:0]       fv_q, diff_q, rd_q;
  logic                    neg_q, seeded_q;
  logic [PROD_W-1:0]       prod_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [CNT_W-1:0]        filled_q, rem_q;
  logic [TOT_W-1:0]        total_q, div_q;
  logic [ITER_W-1:0]       iter_q;
  logic                    out_valid_q;
  logic [OUT_DATA_W-1:0]   out_data_q;

  logic [DATA_W-1:0]       hist_mem [WINDOW_LEN];

  logic [DATA_W-1:0]       target;
  logic [GAIN_W-1:0]       alpha;
  logic [DATA_W-1:0]       step;
  logic                    full;
  logic [TOT_W-1:0]        total_d;
  logic [CNT_W:0]          trial;
  logic                    trial_ge;
  logic [CNT_W-1:0]        rem_d;

  assign target   = {raw_q, {FRAC_W{1'b0}}};
  assign alpha    = (gain_q > GAIN_ONE) ? GAIN_ONE : gain_q;
  assign step     = prod_q[GAIN_FRAC_W +: DATA_W];
  assign full     = (filled_q == CNT_W'(WINDOW_LEN));
  assign total_d  = total_q - (full ? TOT_W'(rd_q) : '0) + TOT_W'(fv_q);
  assign trial    = {rem_q, div_q[TOT_W-1]};
  assign trial_ge = (trial >= {1'b0, filled_q});
  assign rem_d    = trial_ge ? CNT_W'(trial - {1'b0, filled_q}) : trial[CNT_W-1:0];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      rd_q <= hist_mem[slot_q];
    end
    if (state_q == ST_WRITE) begin
      hist_mem[slot_q] <= fv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= GAIN_RESET;
      cnt_q       <= '0;
      prev_q      <= '0;
      ok_q        <= 1'b0;
      raw_q       <= '0;
      fv_q        <= '0;
      diff_q      <= '0;
      neg_q       <= 1'b0;
      seeded_q    <= 1'b0;
      prod_q      <= '0;
      slot_q      <= '0;
      filled_q    <= '0;
      total_q     <= '0;
      div_q       <= '0;
      rem_q       <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        gain_q <= cfg_data_i;
      end
      if (out_valid_q && m_axis_tready_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            cnt_q   <= s_axis_tdata_i[COUNTER_W-1:0];
            raw_q   <= s_axis_tdata_i[COUNTER_W +: RAW_W];
            ok_q    <= s_axis_tuser_i;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (cnt_q < prev_q) begin
            prev_q   <= '0;
            slot_q   <= '0;
            filled_q <= '0;
            fv_q     <= '0;
            total_q  <= '0;
            seeded_q <= 1'b0;
          end
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          div_q  <= total_q;
          rem_q  <= '0;
          iter_q <= '0;
          if (cnt_q == prev_q) begin
            state_q <= ST_DIV;
          end else begin
            prev_q <= cnt_q;
            if (cnt_q == '0 || !ok_q) begin
              state_q <= ST_DIV;
            end else begin
              neg_q   <= (target < fv_q);
              diff_q  <= (target < fv_q) ? (fv_q - target) : (target - fv_q);
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_q  <= PROD_W'(alpha) * PROD_W'(diff_q);
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          if (!seeded_q) begin
            fv_q <= target;
          end else if (neg_q) begin
            fv_q <= fv_q - step;
          end else begin
            fv_q <= fv_q + step;
          end
          seeded_q <= 1'b1;
          state_q  <= ST_WRITE;
        end
        ST_WRITE: begin
          total_q <= total_d;
          div_q   <= total_d;
          rem_q   <= '0;
          iter_q  <= '0;
          if (!full) begin
            filled_q <= filled_q + 1'b1;
          end
          slot_q  <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          div_q  <= {div_q[TOT_W-2:0], trial_ge};
          rem_q  <= rem_d;
          iter_q <= iter_q + 1'b1;
          if (iter_q == ITER_W'(TOT_W - 1)) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {(filled_q == '0) ? DATA_W'(0) : div_q[DATA_W-1:0], fv_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/rlma_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the range low-pass and moving-average filter, and the
// bind that attaches them to the top level. Depends on rlma_pkg.
module rlma_checker
  import rlma_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled result changed or dropped.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[DATA_W-1:0] <= DATA_MAX)
                     && (m_axis_tdata_o[OUT_DATA_W-1:DATA_W] <= DATA_MAX))
    else $error("Result outside the Q16.8 distance range.");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("Result appeared right after an input transfer.");

  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("Result valid directly after reset.");

endmodule

bind range_lowpass_moving_average rlma_checker u_rlma_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
